/* rtl/gost_pkg.sv */
package gost_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_KEYS = 8;
    localparam int KEY_IW   = $clog2(NUM_KEYS);
    localparam int ROUNDS   = 32;
    localparam int ROUND_W  = $clog2(ROUNDS);
    localparam int CFG_IW   = 4;
    localparam int ROT      = 11;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [KEY_IW-1:0] key_sel;
        logic              out_load;
    } t_cmd;

    typedef logic [3:0] t_sbox_row [16];

    localparam t_sbox_row SBOX [8] = '{
        '{4'h4, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE,
          4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h3},
        '{4'hE, 4'hB, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA,
          4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
        '{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2,
          4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
        '{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF,
          4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3},
        '{4'h6, 4'hC, 4'h7, 4'h1, 4'h5, 4'hF, 4'hD, 4'h8,
          4'h4, 4'hA, 4'h9, 4'hE, 4'h0, 4'h3, 4'hB, 4'h2},
        '{4'h4, 4'hB, 4'hA, 4'h0, 4'h7, 4'h2, 4'h1, 4'hD,
          4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hC, 4'hF, 4'hE},
        '{4'hD, 4'hB, 4'h4, 4'h1, 4'h3, 4'hF, 4'h5, 4'h9,
          4'h0, 4'hA, 4'hE, 4'h7, 4'h6, 4'h8, 4'h2, 4'hC},
        '{4'h1, 4'hF, 4'hD, 4'h0, 4'h5, 4'h7, 4'hA, 4'h4,
          4'h9, 4'h2, 4'h3, 4'hE, 4'h6, 4'hB, 4'h8, 4'hC}
    };

    function automatic t_word round_fn(input t_word half, input t_word rk);
        t_word sum;
        t_word sub;
        sum = half + rk;
        for (int i = 0; i < 8; i++) begin
            sub[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
        end
        return {sub[WORD_W-ROT-1:0], sub[WORD_W-1:WORD_W-ROT]};
    endfunction

endpackage

/* rtl/gost_28147_89_block_cipher_core.sv */
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_op, i_block_low, i_block_high
// output    o_out_valid / i_out_ready   o_out_low, o_out_high
// config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Each block is loaded, then runs 32 rounds, one round per cycle
// through the single round function unit.
// The next request is taken in the cycle its predecessor moves into the output
// register, so back-to-back blocks need no idle cycle while the output drains.
// A stalled output holds the finished block in the core until the register frees.
// Synchronous reset clears the key words to zero and empties the core.
module gost_28147_89_block_cipher_core
    import gost_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  t_word             i_block_low,
    input  t_word             i_block_high,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_word             o_out_low,
    output t_word             o_out_high,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  t_word             i_cfg_data
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    gost_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    gost_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_block_low  (i_block_low),
        .i_block_high (i_block_high),
        .o_out_low    (o_out_low),
        .o_out_high   (o_out_high)
    );

endmodule

/* rtl/gost_datapath.sv */
module gost_datapath
    import gost_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  t_word             i_cfg_data,
    input  t_word             i_block_low,
    input  t_word             i_block_high,
    output t_word             o_out_low,
    output t_word             o_out_high
);

    t_word r_key [NUM_KEYS];
    t_word r_x;
    t_word r_y;
    t_word r_out_low;
    t_word r_out_high;
    t_word n_x;

    assign n_x = r_y ^ round_fn(r_x, r_key[i_cmd.key_sel]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_IW'(NUM_KEYS))) begin
            r_key[i_cfg_index[KEY_IW-1:0]] <= i_cfg_data;
        end
        if (i_cmd.out_load) begin
            r_out_low  <= r_y;
            r_out_high <= r_x;
        end
        if (i_cmd.load) begin
            r_x <= i_block_low;
            r_y <= i_block_high;
        end else if (i_cmd.step) begin
            r_x <= n_x;
            r_y <= r_x;
        end
    end

    assign o_out_low  = r_out_low;
    assign o_out_high = r_out_high;

endmodule

/* rtl/gost_ctrl.sv */
module gost_ctrl
    import gost_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_op,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    t_state               r_state;
    logic [ROUND_W-1:0]   r_round;
    logic                 r_op;
    logic                 r_out_valid;
    logic                 out_free;
    logic                 accept;
    logic                 out_load;
    logic [KEY_IW-1:0]    key_fwd;
    logic [KEY_IW-1:0]    key_rev;

    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = (r_state == ST_FIN) && out_free;
    assign o_in_ready = (r_state == ST_IDLE) || out_load;
    assign accept     = i_in_valid && o_in_ready;

    // Encryption runs the key words forward for 24 rounds then backward;
    // decryption runs forward for the first 8 rounds then backward.
    assign key_fwd = r_round[KEY_IW-1:0];
    assign key_rev = ~r_round[KEY_IW-1:0];

    always_comb begin
        o_cmd.load     = accept;
        o_cmd.step     = (r_state == ST_RUN);
        o_cmd.out_load = out_load;
        if (r_op == OP_DECRYPT) begin
            o_cmd.key_sel = (r_round < ROUND_W'(NUM_KEYS)) ? key_fwd : key_rev;
        end else begin
            o_cmd.key_sel = (r_round < ROUND_W'(ROUNDS - NUM_KEYS)) ? key_fwd : key_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_op        <= OP_ENCRYPT;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_RUN;
                        r_round <= '0;
                        r_op    <= i_op;
                    end
                end
                ST_RUN: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == ROUND_W'(ROUNDS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (accept) begin
                        r_state <= ST_RUN;
                        r_round <= '0;
                        r_op    <= i_op;
                    end else if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* bench/tb_gost_28147_89_block_cipher_core.sv */
`timescale 1ns / 100ps

module tb_gost_28147_89_block_cipher_core;
    import gost_pkg::*;

    typedef struct packed {
        logic  op;
        t_word low;
        t_word high;
    } t_block_req;

    typedef struct packed {
        t_word low;
        t_word high;
    } t_cipher_out;

    // Substitution rows in natural order: entry 0 is the leftmost nibble of each row.
    localparam logic [511:0] SUBST = {
        64'h4A92D80E6B1C7F53, 64'hEB4C6DFA23810759,
        64'h581DA342EFC7609B, 64'h7DA1089FE46CB253,
        64'h6C715FD84A9E03B2, 64'h4BA0721D36859CFE,
        64'hDB413F590AE7682C, 64'h1FD057A4923E6B8C
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_op = OP_ENCRYPT;
    t_word             i_block_low = '0;
    t_word             i_block_high = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_word             o_out_low;
    t_word             o_out_high;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    t_word             i_cfg_data = '0;

    t_word       key_words [NUM_KEYS];
    t_block_req  block_backlog [$];
    t_cipher_out cipher_due [$];
    int          blocks_queued = 0;
    int          blocks_returned = 0;
    int          mismatch_cnt = 0;
    int          send_gap_pct = 0;
    int          sink_stall_pct = 0;

    gost_28147_89_block_cipher_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_block_low  (i_block_low),
        .i_block_high (i_block_high),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_low    (o_out_low),
        .o_out_high   (o_out_high),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_word gost_mix(t_word half, t_word rk);
        t_word sum;
        t_word sub;
        sum = half + rk;
        for (int i = 0; i < 8; i++) begin
            sub[4*i +: 4] = SUBST[511 - 64*i - 4*sum[4*i +: 4] -: 4];
        end
        return (sub << 11) | (sub >> 21);
    endfunction

    function automatic t_cipher_out gost_block(logic op, t_word n1, t_word n2);
        int          rnd;
        t_word       rk;
        t_cipher_out res;
        for (int r = 0; r < 32; r++) begin
            rnd = (op == OP_DECRYPT) ? 31 - r : r;
            rk  = (rnd < 24) ? key_words[rnd % 8] : key_words[(31 - rnd) % 8];
            if (r % 2 == 0) begin
                n2 ^= gost_mix(n1, rk);
            end else begin
                n1 ^= gost_mix(n2, rk);
            end
        end
        res.low  = n2;
        res.high = n1;
        return res;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return t_word'(1) << $urandom_range(0, 31);
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        mismatch_cnt++;
        $display("%0t: %s: got %08h, expected %08h", $time, what, got, want);
    endtask

    task automatic queue_block(input logic op, input t_word lo, input t_word hi);
        t_block_req rq;
        rq.op   = op;
        rq.low  = lo;
        rq.high = hi;
        block_backlog.push_back(rq);
        blocks_queued++;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (blocks_returned < blocks_queued);
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input t_word data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_KEYS) begin
            key_words[idx] = data;
        end
    endtask

    task automatic load_random_key(input int flavour);
        t_word kw;
        for (int i = 0; i < NUM_KEYS; i++) begin
            kw = (flavour == 1) ? 32'h0 : (flavour == 2) ? 32'hFFFF_FFFF : rand_word();
            cfg_write(CFG_IW'(i), kw);
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(CFG_IW'($urandom_range(NUM_KEYS, 2**CFG_IW - 1)),
                          t_word'($urandom));
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_block_req rq;
        int         gap_left;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cipher_due.push_back(gost_block(i_op, i_block_low, i_block_high));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (block_backlog.size() != 0
                             && $urandom_range(0, 99) < send_gap_pct) begin
                    gap_left = $urandom_range(1, 15) - 1;
                    i_in_valid <= 1'b0;
                end else if (block_backlog.size() != 0) begin
                    rq = block_backlog.pop_front();
                    i_in_valid   <= 1'b1;
                    i_op         <= rq.op;
                    i_block_low  <= rq.low;
                    i_block_high <= rq.high;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_cipher_out want;
        int          stall_left;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                blocks_returned++;
                if (cipher_due.size() == 0) begin
                    report_mismatch("result with no request outstanding", o_out_low, '0);
                end else begin
                    want = cipher_due.pop_front();
                    if (o_out_low !== want.low) begin
                        report_mismatch("out_low", o_out_low, want.low);
                    end
                    if (o_out_high !== want.high) begin
                        report_mismatch("out_high", o_out_high, want.high);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_stall_pct) begin
                stall_left = $urandom_range(1, 15) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_cipher_out ct;
        t_word       a;
        t_word       b;
        for (int i = 0; i < NUM_KEYS; i++) begin
            key_words[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The key words are still at their reset value here.
        queue_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
        queue_block(OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
        wait_idle();

        for (int i = 0; i < NUM_KEYS; i++) begin
            cfg_write(CFG_IW'(i), 32'hFFFF_FFFF);
        end
        cfg_write(CFG_IW'(NUM_KEYS), 32'h0000_0000);
        cfg_write(CFG_IW'(2**CFG_IW - 1), 32'h1234_5678);
        i_cfg_valid <= 1'b0;
        send_gap_pct   = 30;
        sink_stall_pct = 30;
        queue_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_block(OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_block(OP_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        wait_idle();

        for (int i = 0; i < NUM_KEYS; i++) begin
            cfg_write(CFG_IW'(i), 32'h0123_4567 * (i + 1) ^ 32'hF0E1_D2C3);
        end
        cfg_write(CFG_IW'(NUM_KEYS + 3), 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        for (int i = 0; i < 3; i++) begin
            a  = t_word'($urandom);
            b  = t_word'($urandom);
            ct = gost_block(OP_ENCRYPT, a, b);
            queue_block(OP_ENCRYPT, a, b);
            queue_block(OP_DECRYPT, ct.low, ct.high);
        end
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            load_random_key((p == 1) ? 1 : (p == 4) ? 2 : 0);
            send_gap_pct   = (p == 2) ? 0 : 10 + 15 * p;
            sink_stall_pct = (p == 2) ? 0 : 60 - 10 * p;
            for (int n = 0; n < 110; n++) begin
                queue_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
            end
            wait_idle();
        end

        send_gap_pct   = 0;
        sink_stall_pct = 0;
        load_random_key(0);
        for (int n = 0; n < 40; n++) begin
            queue_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
        end
        wait_idle();
        repeat (40) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/gost_pkg.sv
rtl/gost_datapath.sv
rtl/gost_ctrl.sv
rtl/gost_28147_89_block_cipher_core.sv
bench/tb_gost_28147_89_block_cipher_core.sv
